FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

FILE: rtl/irpw_pkg.sv
package irpw_pkg;

    localparam int MAX_PAYLOAD   = 32;
    localparam int BITS_PER_BYTE = 8;
    localparam int MAX_TRAILER   = 4;

    localparam int POS_W     = 6;
    localparam int SUM_W     = 13;
    localparam int TLEN_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 6;
    localparam int DUR_W     = 3;

    // Start mark (two segments) plus two segments per bit.
    localparam int SEGS_PER_BYTE = 2 + 2 * BITS_PER_BYTE;
    localparam int SEG_W         = $clog2(SEGS_PER_BYTE);

    // Checksum split: x / 100 == (x * 5243) >> 19 for every 13-bit x.
    localparam int CHECK_DIVISOR = 100;
    localparam int RECIP_100     = 5243;
    localparam int RECIP_SHIFT   = 19;
    localparam int PROD_W        = 2 * SUM_W;
    localparam int QUOT_W        = 7;

    localparam logic [POS_W-1:0]  PLEN_RESET = POS_W'(18);
    localparam logic [TLEN_W-1:0] TLEN_RESET = TLEN_W'(2);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PAYLOAD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TRAILER = CFG_IDX_W'(1);

    // Opcodes.
    localparam logic OP_FRAME  = 1'b0;
    localparam logic OP_SINGLE = 1'b1;

    // Segment durations in 0.6 ms units.
    localparam logic [DUR_W-1:0] DUR_MARK  = DUR_W'(4);
    localparam logic [DUR_W-1:0] DUR_SHORT = DUR_W'(1);
    localparam logic [DUR_W-1:0] DUR_LONG  = DUR_W'(2);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic                     opcode;
        logic [BITS_PER_BYTE-1:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic             led_on;
        logic [DUR_W-1:0] duration_units;
        logic             frame_end;
        logic             last;
    } out_item_t;

    // One classified byte handed from the front to the back.
    typedef struct packed {
        logic [BITS_PER_BYTE-1:0] data_byte;
        logic                     has_check;
        logic [SUM_W-1:0]         sum;
        logic                     ends;
    } job_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

endpackage

FILE: rtl/ir_pulse_width_frame_sender.sv
// Throughput: one segment per cycle while a byte is being sent and m_ready holds.
// Each byte is a start mark and two segments per bit; a payload-closing byte is sent as
// data, quotient and remainder bytes.
// A two-entry queue lets further bytes be accepted while earlier ones are still being sent.
// Reset (aresetn low, synchronous): frame position, checksum, queue and output cleared;
// payload_length returns to 18 and trailer_length to 2.
module ir_pulse_width_frame_sender
    import irpw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data
);

    q_status_t q_stat;
    logic      q_push;
    logic      q_pop;
    job_t      push_job;
    job_t      pop_job;

    irpw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    irpw_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .stat     (q_stat)
    );

    irpw_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_stat  (q_stat),
        .q_job   (pop_job),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: rtl/irpw_front.sv
module irpw_front
    import irpw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    input  q_status_t            q_stat,
    output logic                 q_push,
    output job_t                 q_job
);

    logic [POS_W-1:0]  plen_reg;
    logic [TLEN_W-1:0] tlen_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;

    logic [POS_W-1:0]  plen_eff;
    logic [TLEN_W-1:0] tlen_eff;
    logic [POS_W-1:0]  pos_inc;
    logic [SUM_W-1:0]  sum_base;
    logic              accept;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept;

    always_comb begin
        if (plen_reg == '0) begin
            plen_eff = POS_W'(1);
        end else if (plen_reg > POS_W'(MAX_PAYLOAD)) begin
            plen_eff = POS_W'(MAX_PAYLOAD);
        end else begin
            plen_eff = plen_reg;
        end
        tlen_eff = (tlen_reg > TLEN_W'(MAX_TRAILER)) ? TLEN_W'(MAX_TRAILER) : tlen_reg;
    end

    // Classify the transaction and work out the frame state it leaves.
    always_comb begin
        pos_inc           = pos_reg + POS_W'(1);
        sum_base          = (pos_reg == '0) ? '0 : sum_reg;
        pos_next          = pos_reg;
        sum_next          = sum_reg;
        q_job.data_byte   = s_data.data_byte;
        q_job.has_check   = 1'b0;
        q_job.sum         = sum_reg;
        q_job.ends        = 1'b0;
        if (s_data.opcode == OP_SINGLE) begin
            q_job.ends = 1'b1;
        end else if (pos_reg < plen_eff) begin
            sum_next  = sum_base + SUM_W'(s_data.data_byte);
            q_job.sum = sum_next;
            pos_next  = pos_inc;
            if (pos_inc >= plen_eff) begin
                q_job.has_check = 1'b1;
                if (tlen_eff == '0) begin
                    q_job.ends = 1'b1;
                    pos_next   = '0;
                end
            end
        end else begin
            if ({1'b0, pos_reg} + (POS_W+1)'(1) >=
                {1'b0, plen_eff} + (POS_W+1)'(tlen_eff)) begin
                q_job.ends = 1'b1;
                pos_next   = '0;
            end else begin
                pos_next = pos_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg <= PLEN_RESET;
            tlen_reg <= TLEN_RESET;
            pos_reg  <= '0;
            sum_reg  <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_IDX_PAYLOAD: plen_reg <= cfg_wdata;
                    CFG_IDX_TRAILER: tlen_reg <= cfg_wdata[TLEN_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                pos_reg <= pos_next;
                sum_reg <= sum_next;
            end
        end
    end

endmodule

FILE: rtl/irpw_queue.sv
`include "assert_macros.svh"

module irpw_queue
    import irpw_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      pop_job,
    output q_status_t stat
);

    job_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg;

    assign stat.valid = (cnt_reg != '0);
    assign stat.full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign pop_job    = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + Q_CNT_W'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - Q_CNT_W'(1);
            end
        end
    end

    `ASSERT_PROP(a_push_not_full, aclk, aresetn, push |-> !stat.full, "push into full queue")
    `ASSERT_PROP(a_pop_not_empty, aclk, aresetn, pop |-> stat.valid, "pop from empty queue")

endmodule

FILE: rtl/irpw_back.sv
`include "assert_macros.svh"

module irpw_back
    import irpw_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  q_status_t q_stat,
    input  job_t      q_job,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DATA = 4'b0010,
        ST_QUOT = 4'b0100,
        ST_REM  = 4'b1000
    } byte_state_t;

    byte_state_t              state_reg;
    job_t                     job_reg;
    logic [SEG_W-1:0]         seg_reg;
    logic [BITS_PER_BYTE-1:0] shift_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [QUOT_W-1:0]        quot_reg;
    logic [QUOT_W-1:0]        rem_reg;
    logic                     m_valid_reg;
    out_item_t                m_data_reg;

    logic             out_adv;
    logic             busy;
    logic             seg_last;
    logic             final_byte;
    logic             emit;
    logic [SUM_W-1:0] rem_full;
    out_item_t        seg;

    assign out_adv    = !m_valid_reg || m_ready;
    assign busy       = (state_reg != ST_IDLE);
    assign seg_last   = (seg_reg == SEG_W'(SEGS_PER_BYTE - 1));
    assign final_byte = ((state_reg == ST_DATA) && !job_reg.has_check) || (state_reg == ST_REM);
    assign emit       = busy && out_adv;
    assign q_pop      = q_stat.valid && (!busy || (emit && seg_last && final_byte));

    // Segment for the current position in the byte: start mark, then mark/space per bit.
    always_comb begin
        seg.last      = seg_last && final_byte;
        seg.frame_end = seg_last && final_byte && job_reg.ends;
        if (seg_reg == SEG_W'(0)) begin
            seg.led_on         = 1'b1;
            seg.duration_units = DUR_MARK;
        end else if (seg_reg == SEG_W'(1)) begin
            seg.led_on         = 1'b0;
            seg.duration_units = DUR_SHORT;
        end else if (!seg_reg[0]) begin
            seg.led_on         = 1'b1;
            seg.duration_units = shift_reg[BITS_PER_BYTE-1] ? DUR_LONG : DUR_SHORT;
        end else begin
            seg.led_on         = 1'b0;
            seg.duration_units = shift_reg[BITS_PER_BYTE-1] ? DUR_SHORT : DUR_LONG;
        end
    end

    // Checksum split, settled long before the data byte finishes.
    assign rem_full = job_reg.sum - SUM_W'(quot_reg) * SUM_W'(CHECK_DIVISOR);

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(job_reg.sum) * PROD_W'(RECIP_100);
        quot_reg <= prod_reg[RECIP_SHIFT +: QUOT_W];
        rem_reg  <= rem_full[QUOT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg   <= q_job;
            shift_reg <= q_job.data_byte;
        end else if (emit) begin
            if (seg_last) begin
                if (state_reg == ST_DATA) begin
                    shift_reg <= BITS_PER_BYTE'(quot_reg);
                end else begin
                    shift_reg <= BITS_PER_BYTE'(rem_reg);
                end
            end else if (seg_reg[0] && seg_reg != SEG_W'(1)) begin
                // advance to the next bit after its space
                shift_reg <= {shift_reg[BITS_PER_BYTE-2:0], 1'b0};
            end
        end
        if (emit) begin
            m_data_reg <= seg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            seg_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                state_reg <= ST_DATA;
                seg_reg   <= '0;
            end else if (emit) begin
                if (seg_last) begin
                    seg_reg <= '0;
                    unique case (state_reg)
                        ST_DATA: state_reg <= job_reg.has_check ? ST_QUOT : ST_IDLE;
                        ST_QUOT: state_reg <= ST_REM;
                        ST_REM:  state_reg <= ST_IDLE;
                        default: state_reg <= ST_IDLE;
                    endcase
                end else begin
                    seg_reg <= seg_reg + SEG_W'(1);
                end
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_PROP(a_end_is_last, aclk, aresetn, (m_valid_reg && m_data_reg.frame_end) |-> m_data_reg.last, "frame end without last")
    `ASSERT_PROP(a_dur_range, aclk, aresetn, m_valid_reg |-> (m_data_reg.duration_units != '0 && m_data_reg.duration_units <= DUR_MARK), "bad segment duration")
    `ASSERT_NEVER(a_seg_range, aclk, aresetn, seg_reg > SEG_W'(SEGS_PER_BYTE - 1), "segment index past end of byte")

endmodule
